// ===== design/fmr_pkg.sv =====
// Shared constants, controller state codes and controller/datapath interface
// structs for the framed message receiver. No dependencies.
package fmr_pkg;

  localparam int MAX_DATA = 32;
  localparam int STORE_AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  localparam logic [7:0] SOF_BYTE = 8'h7F;

  typedef enum logic [7:0] {
    S_HUNT   = 8'b0000_0001,
    S_TYPE   = 8'b0000_0010,
    S_SIZE   = 8'b0000_0100,
    S_SER_LO = 8'b0000_1000,
    S_SER_HI = 8'b0001_0000,
    S_DATA   = 8'b0010_0000,
    S_READ   = 8'b0100_0000,
    S_LOAD   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic ld_type;
    logic ld_size;
    logic ld_ser_lo;
    logic ld_ser_hi;
    logic wr_data;
    logic clr_idx;
    logic inc_idx;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic sof;
    logic size_zero;
    logic data_done;
    logic single;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

// ===== design/fmr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fmr_datapath.sv =====
// Header registers, payload store, result register and configuration register
// of the framed message receiver. Depends on fmr_pkg and fmr_ram.
module fmr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  fmr_pkg::cmd_t      cmd,
  output fmr_pkg::status_t   status,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_ack,
  output logic [7:0]         msg_type,
  output logic [6:0]         kept_size,
  output logic [15:0]        serial_number,
  output logic [7:0]         payload_byte,
  output logic [5:0]         payload_index,
  output logic               last
);

  logic [7:0]                   ack_type_code;
  logic [7:0]                   frame_type;
  logic [7:0]                   declared_size;
  logic [15:0]                  frame_serial;
  logic [7:0]                   bytes_seen;
  logic [fmr_pkg::STORE_AW-1:0] idx;
  logic [6:0]                   kept;
  logic [7:0]                   rdata;
  logic                         store_we;
  logic                         is_ack_type;
  logic                         single;
  logic                         idx_last;

  always_comb begin
    kept = (declared_size > 8'(fmr_pkg::MAX_DATA)) ? 7'(fmr_pkg::MAX_DATA)
                                                   : declared_size[6:0];
    is_ack_type = (frame_type == ack_type_code);
    single = is_ack_type || (declared_size == 8'd0);
    idx_last = (7'(idx) + 7'd1) == kept;
    store_we = cmd.wr_data && (bytes_seen < 8'(fmr_pkg::MAX_DATA));
  end

  always_comb begin
    status.sof       = (rx_byte == fmr_pkg::SOF_BYTE);
    status.size_zero = (declared_size == 8'd0);
    status.data_done = (8'(bytes_seen + 8'd1) == declared_size);
    status.single    = single;
    status.idx_last  = idx_last;
    status.out_free  = !out_valid || !out_stall;
  end

  fmr_ram #(
    .WIDTH(8),
    .DEPTH(fmr_pkg::MAX_DATA)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(bytes_seen[fmr_pkg::STORE_AW-1:0]),
    .wdata(rx_byte),
    .raddr(idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_type_code <= 8'd0;
      out_valid     <= 1'b0;
      bytes_seen    <= 8'd0;
      idx           <= '0;
    end else begin
      if (cfg_wr_en) begin
        ack_type_code <= cfg_wr_data;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.ld_ser_hi) begin
        bytes_seen <= 8'd0;
      end else if (cmd.wr_data) begin
        bytes_seen <= 8'(bytes_seen + 8'd1);
      end
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_type) begin
      frame_type <= rx_byte;
    end
    if (cmd.ld_size) begin
      declared_size <= rx_byte;
    end
    if (cmd.ld_ser_lo) begin
      frame_serial[7:0] <= rx_byte;
    end
    if (cmd.ld_ser_hi) begin
      frame_serial[15:8] <= rx_byte;
    end
    if (cmd.emit) begin
      is_ack        <= is_ack_type;
      msg_type      <= frame_type;
      kept_size     <= kept;
      serial_number <= frame_serial;
      payload_byte  <= single ? 8'd0 : rdata;
      payload_index <= single ? 6'd0 : 6'(idx);
      last          <= single || idx_last;
    end
  end

endmodule

// ===== design/fmr_ctrl.sv =====
// Controller state machine of the framed message receiver: frame parsing and
// result sequencing. Depends on fmr_pkg.
module fmr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  fmr_pkg::status_t status,
  output fmr_pkg::cmd_t    cmd
);

  fmr_pkg::state_t state;
  fmr_pkg::state_t state_next;
  logic            in_xfer;

  always_comb begin
    in_stall = (state == fmr_pkg::S_READ) || (state == fmr_pkg::S_LOAD);
    in_xfer  = in_valid && !in_stall;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      fmr_pkg::S_HUNT: begin
        if (in_xfer && status.sof) begin
          state_next = fmr_pkg::S_TYPE;
        end
      end
      fmr_pkg::S_TYPE: begin
        if (in_xfer) begin
          cmd.ld_type = 1'b1;
          state_next  = fmr_pkg::S_SIZE;
        end
      end
      fmr_pkg::S_SIZE: begin
        if (in_xfer) begin
          cmd.ld_size = 1'b1;
          state_next  = fmr_pkg::S_SER_LO;
        end
      end
      fmr_pkg::S_SER_LO: begin
        if (in_xfer) begin
          cmd.ld_ser_lo = 1'b1;
          state_next    = fmr_pkg::S_SER_HI;
        end
      end
      fmr_pkg::S_SER_HI: begin
        if (in_xfer) begin
          cmd.ld_ser_hi = 1'b1;
          cmd.clr_idx   = 1'b1;
          state_next    = status.size_zero ? fmr_pkg::S_READ : fmr_pkg::S_DATA;
        end
      end
      fmr_pkg::S_DATA: begin
        if (in_xfer) begin
          cmd.wr_data = 1'b1;
          if (status.data_done) begin
            cmd.clr_idx = 1'b1;
            state_next  = fmr_pkg::S_READ;
          end
        end
      end
      fmr_pkg::S_READ: begin
        state_next = fmr_pkg::S_LOAD;
      end
      fmr_pkg::S_LOAD: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.single || status.idx_last) begin
            state_next = fmr_pkg::S_HUNT;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next  = fmr_pkg::S_READ;
          end
        end
      end
      default: begin
        state_next = fmr_pkg::S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmr_pkg::S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/framed_message_receiver.sv =====
// Top level of the framed message receiver: joins the controller and the
// datapath. Depends on fmr_pkg, fmr_ctrl and fmr_datapath.
//
//   channel  signals                          transfer when
//   input    in_valid, in_stall, rx_byte      in_valid && !in_stall
//   output   out_valid, out_stall, fields     out_valid && !out_stall
//   config   cfg_wr_en, cfg_wr_data           cfg_wr_en
//
// Received bytes are taken whenever the input does not stall. After the final
// byte of a frame the input stalls while results are produced; each result
// passes a read state and a load state, as the store read is registered. A frame
// gives one to MAX_DATA results. Output stall holds the result register and
// pauses the sequence. Reset is synchronous and returns the parser to the start byte hunt.
module framed_message_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_ack,
  output logic [7:0]  msg_type,
  output logic [6:0]  kept_size,
  output logic [15:0] serial_number,
  output logic [7:0]  payload_byte,
  output logic [5:0]  payload_index,
  output logic        last
);

  fmr_pkg::cmd_t    cmd;
  fmr_pkg::status_t status;

  fmr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  fmr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_ack       (is_ack),
    .msg_type     (msg_type),
    .kept_size    (kept_size),
    .serial_number(serial_number),
    .payload_byte (payload_byte),
    .payload_index(payload_index),
    .last         (last)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for framed_message_receiver: directed frames, then random frames under four
// acknowledge-type settings, checked against a byte-level frame predictor; directed
// rows may replace its results. Depends on fmr_pkg and the framed_message_receiver RTL.
module tb;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int HOLDOFF = 8;
  localparam int PHASE_ITEMS = 4;

  typedef enum logic [2:0] {
    P_HUNT, P_TYPE, P_SIZE, P_SER_LO, P_SER_HI, P_DATA
  } parse_phase_t;

  typedef struct packed {
    logic        is_ack;
    logic [7:0]  msg_type;
    logic [6:0]  kept_size;
    logic [15:0] serial_number;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    logic        last;
  } frame_result_t;

  typedef struct {
    logic [7:0]    value;
    bit            typed;
    frame_result_t res;
  } directed_row_t;

  localparam frame_result_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_ack;
  logic [7:0]  msg_type;
  logic [6:0]  kept_size;
  logic [15:0] serial_number;
  logic [7:0]  payload_byte;
  logic [5:0]  payload_index;
  logic        last;

  frame_result_t pending_results[$];
  int error_count = 0;
  int phase_items = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit moved;
  bit sender_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  parse_phase_t rx_phase = P_HUNT;
  logic [7:0]  ack_code = 8'h00;
  logic [7:0]  cur_type = 8'h00;
  logic [7:0]  cur_size = 8'h00;
  logic [7:0]  seen = 8'h00;
  logic [15:0] cur_serial = 16'h0000;
  logic [7:0]  kept_bytes [fmr_pkg::MAX_DATA];

  // Frames after reset, with the acknowledge type still at zero.
  directed_row_t directed_rows [25] = '{
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h34, 1'b0, NO_RESULT},
    '{8'h12, 1'b1, '{1'b1, 8'h00, 7'd0, 16'h1234, 8'h00, 6'd0, 1'b1}},
    '{8'h7F, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, '{1'b0, 8'hFF, 7'd0, 16'hFFFF, 8'h00, 6'd0, 1'b1}},
    '{8'h7F, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, NO_RESULT},
    '{8'h7F, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h7F, 1'b1, '{1'b1, 8'h00, 7'd1, 16'h0080, 8'h00, 6'd0, 1'b1}}
  };

  framed_message_receiver uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_ack(is_ack),
    .msg_type(msg_type),
    .kept_size(kept_size),
    .serial_number(serial_number),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .last(last)
  );

  always #5 clk = ~clk;

  function automatic void close_frame();
    int kept;
    frame_result_t r;
    kept = (cur_size > fmr_pkg::MAX_DATA) ? fmr_pkg::MAX_DATA : cur_size;
    rx_phase = P_HUNT;
    r = '0;
    r.msg_type = cur_type;
    r.kept_size = kept[6:0];
    r.serial_number = cur_serial;
    r.last = 1'b1;
    if (cur_type == ack_code) begin
      r.is_ack = 1'b1;
      pending_results.push_back(r);
    end else if (kept == 0) begin
      pending_results.push_back(r);
    end else begin
      for (int i = 0; i < kept; i++) begin
        r.payload_byte = kept_bytes[i[4:0]];
        r.payload_index = i[5:0];
        r.last = (i == kept - 1);
        pending_results.push_back(r);
      end
    end
  endfunction

  function automatic void track_byte(input logic [7:0] b);
    case (rx_phase)
      P_TYPE: begin
        cur_type = b;
        rx_phase = P_SIZE;
      end
      P_SIZE: begin
        cur_size = b;
        rx_phase = P_SER_LO;
      end
      P_SER_LO: begin
        cur_serial = {8'h00, b};
        rx_phase = P_SER_HI;
      end
      P_SER_HI: begin
        cur_serial[15:8] = b;
        seen = 8'h00;
        if (cur_size == 8'h00) close_frame();
        else rx_phase = P_DATA;
      end
      P_DATA: begin
        if (seen < fmr_pkg::MAX_DATA) kept_bytes[seen[4:0]] = b;
        seen = seen + 8'h01;
        if (seen == cur_size) close_frame();
      end
      default: begin
        rx_phase = (b == fmr_pkg::SOF_BYTE) ? P_TYPE : P_HUNT;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (error_count < 40) $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  task automatic check_result();
    frame_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none expected", serial_number, 16'h0000);
      return;
    end
    want = pending_results.pop_front();
    if (is_ack !== want.is_ack)
      report_mismatch("is_ack", 16'(is_ack), 16'(want.is_ack));
    if (msg_type !== want.msg_type)
      report_mismatch("msg_type", 16'(msg_type), 16'(want.msg_type));
    if (kept_size !== want.kept_size)
      report_mismatch("kept_size", 16'(kept_size), 16'(want.kept_size));
    if (serial_number !== want.serial_number)
      report_mismatch("serial_number", serial_number, want.serial_number);
    if (payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", 16'(payload_byte), 16'(want.payload_byte));
    if (payload_index !== want.payload_index)
      report_mismatch("payload_index", 16'(payload_index), 16'(want.payload_index));
    if (last !== want.last) report_mismatch("last", 16'(last), 16'(want.last));
  endtask

  // Output side: checks every result transfer, draws stalls and watches for a hang.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      idle_cycles = 0;
    end else begin
      moved = (in_valid && !in_stall) || (out_valid && !out_stall);
      if (out_valid && !out_stall) begin
        check_result();
        if ($urandom_range(0, 7) == 0) recv_quiet = !recv_quiet;
        stall_left = recv_quiet ? 0 : int'($urandom_range(0, 12));
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t res);
    int n0;
    int gap;
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n0 = pending_results.size();
    track_byte(b);
    if (typed) begin
      while (pending_results.size() > n0) void'(pending_results.pop_back());
      pending_results.push_back(res);
    end
    phase_items++;
    gap = sender_quiet ? 0 : int'($urandom_range(0, 12));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOLDOFF) @(posedge clk);
  endtask

  task automatic write_ack_code(input logic [7:0] code);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ack_code = code;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fsize);
    send_byte(fmr_pkg::SOF_BYTE, 1'b0, NO_RESULT);
    send_byte(ftype, 1'b0, NO_RESULT);
    send_byte(fsize, 1'b0, NO_RESULT);
    send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    repeat (fsize) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
  endtask

  // Mostly well-formed frames; the rest is line noise or a header cut short.
  task automatic random_frame();
    logic [7:0] ftype;
    logic [7:0] fsize;
    int pick;
    sender_quiet = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      ftype = ($urandom_range(0, 2) == 0) ? ack_code : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick < 6) fsize = 8'($urandom_range(0, 6));
      else if (pick < 8) fsize = 8'($urandom_range(7, 31));
      else fsize = 8'($urandom_range(32, 36));
      send_frame(ftype, fsize);
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    end else begin
      send_byte(fmr_pkg::SOF_BYTE, 1'b0, NO_RESULT);
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    end
    if ($urandom_range(0, 7) == 0) wait_drained();
  endtask

  initial begin
    logic [7:0] codes [4];
    codes[0] = 8'hFF;
    codes[1] = 8'h7F;
    codes[2] = 8'($urandom_range(0, 255));
    codes[3] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_byte(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].res);
    wait_drained();
    foreach (codes[p]) begin
      write_ack_code(codes[p]);
      if (p == 0) send_frame(8'h5A, 8'd40);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) random_frame();
      sender_quiet = 1'b0;
      while (rx_phase != P_HUNT) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
      wait_drained();
    end
    repeat (HOLDOFF) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
